// File: src/call_cooccurrence_weight_matrix_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the call co-occurrence weight matrix
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALL_COOCCURRENCE_WEIGHT_MATRIX_DEFINES_SVH
`define CALL_COOCCURRENCE_WEIGHT_MATRIX_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle property
`define CCWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ccwm assertion failed");
// antecedent, then consequent in the next cycle
`define CCWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccwm assertion failed");
`else
`define CCWM_ASSERT(lbl, prop)
`define CCWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/ccwm_pkg.sv
// ----------------------------------------------------------------------------
// ccwm_pkg
// Sizes, codes and shared types of the call co-occurrence weight matrix.
// ----------------------------------------------------------------------------
package ccwm_pkg;

  localparam int NUM_CALLS = 512;
  localparam int MAX_TRACE = 4096;
  localparam int FRAC_BITS = 32;

  localparam int FUNC_W   = 2;
  localparam int MODE_W   = 2;
  localparam int FIELD_W  = 9;
  localparam int WEIGHT_W = 48;
  localparam int COUNT_W  = 13;

  localparam int CALL_W  = $clog2(NUM_CALLS);
  localparam int POS_W   = $clog2(MAX_TRACE + 1);
  localparam int HIST_AW = $clog2(MAX_TRACE);
  localparam int LAST_W  = HIST_AW;
  localparam int WADDR_W = 2 * CALL_W;
  localparam int NUM_W   = ((POS_W - 1 > FRAC_BITS) ? POS_W - 1 : FRAC_BITS) + 1;
  localparam int WALK_W  = (POS_W > CALL_W + 1) ? POS_W : CALL_W + 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [MODE_W-1:0] MODE_CUT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DIV,
    ST_ACC,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RD_WAIT,
    ST_RESP
  } ccwm_state_t;

  // per-call bookkeeping entry
  typedef struct packed {
    logic               seen;
    logic [LAST_W-1:0]  last;
    logic [COUNT_W-1:0] count;
  } ccwm_entry_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  calls_seen;
    logic                status;
  } ccwm_result_t;

endpackage

// File: src/ccwm_in_if.sv
// ----------------------------------------------------------------------------
// ccwm_in_if
// Item channel: valid/ready plus item fields.
// ----------------------------------------------------------------------------
interface ccwm_in_if;
  logic                        valid;
  logic                        ready;
  logic [ccwm_pkg::FUNC_W-1:0]  func;
  logic [ccwm_pkg::FIELD_W-1:0] call_index;
  logic [ccwm_pkg::FIELD_W-1:0] row;
  logic [ccwm_pkg::FIELD_W-1:0] col;

  modport source (output valid, func, call_index, row, col, input ready);
  modport sink   (input valid, func, call_index, row, col, output ready);
endinterface

// File: src/ccwm_out_if.sv
// ----------------------------------------------------------------------------
// ccwm_out_if
// Result channel: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface ccwm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ccwm_pkg::WEIGHT_W-1:0] weight;
  logic [ccwm_pkg::COUNT_W-1:0]  count;
  logic [ccwm_pkg::COUNT_W-1:0]  calls_seen;
  logic                         status;

  modport source (output valid, weight, count, calls_seen, status, input ready);
  modport sink   (input valid, weight, count, calls_seen, status, output ready);
endinterface

// File: src/ccwm_ram.sv
// ----------------------------------------------------------------------------
// ccwm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccwm_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/ccwm_recip.sv
// ----------------------------------------------------------------------------
// ccwm_recip
// Rounded reciprocal (2^F + d/2) / d, restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module ccwm_recip (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ccwm_pkg::POS_W-1:0]  den,
  output logic                        done,
  output logic [ccwm_pkg::NUM_W-1:0]  quo
);

  localparam int NW    = ccwm_pkg::NUM_W;
  localparam int PW    = ccwm_pkg::POS_W;
  localparam int CNT_W = $clog2(NW);

  logic [NW-1:0]    num_r;
  logic [PW-1:0]    rem_r;
  logic [PW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [PW:0] rem_sh;
  logic [PW:0] rem_dif;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_dif = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW - 1);
        rem_r  <= '0;
        den_r  <= den;
        num_r  <= (NW'(1) << ccwm_pkg::FRAC_BITS) + NW'(den >> 1);
      end else if (busy_r) begin
        rem_r <= ge ? rem_dif[PW-1:0] : rem_sh[PW-1:0];
        num_r <= {num_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: src/ccwm_core.sv
// ----------------------------------------------------------------------------
// ccwm_core
// Sequencer over weight, call table and history memories.
// ----------------------------------------------------------------------------
`include "call_cooccurrence_weight_matrix_defines.svh"

module ccwm_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ccwm_pkg::MODE_W-1:0]   mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ccwm_pkg::FUNC_W-1:0]   in_func,
  input  logic [ccwm_pkg::FIELD_W-1:0]  in_call_index,
  input  logic [ccwm_pkg::FIELD_W-1:0]  in_row,
  input  logic [ccwm_pkg::FIELD_W-1:0]  in_col,
  output logic                          res_valid,
  input  logic                          res_taken,
  output ccwm_pkg::ccwm_result_t        res
);

  localparam int CW = ccwm_pkg::CALL_W;
  localparam int PW = ccwm_pkg::POS_W;
  localparam int WW = ccwm_pkg::WALK_W;
  localparam int AW = ccwm_pkg::WADDR_W;
  localparam int EW = $bits(ccwm_pkg::ccwm_entry_t);
  localparam int DW = ccwm_pkg::WEIGHT_W;

  ccwm_pkg::ccwm_state_t state_r, state_nxt;

  logic [CW-1:0] idx_r;
  logic [CW-1:0] wrow_r;
  logic [WW-1:0] walk_cnt_r;
  logic [AW-1:0] sweep_cnt_r;
  logic          sweep_resp_r;
  logic [PW-1:0] pos_r;
  logic          rd_ok_r;
  logic [DW-1:0] res_weight_r;
  logic [ccwm_pkg::COUNT_W-1:0] res_count_r;
  logic          res_status_r;

  // memory ports
  logic          tbl_we, tbl_re;
  logic [CW-1:0] tbl_waddr, tbl_raddr;
  logic [EW-1:0] tbl_wdata, tbl_rdata;
  logic          hist_we, hist_re;
  logic [ccwm_pkg::HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [CW-1:0] hist_wdata, hist_rdata;
  logic          wgt_we, wgt_re;
  logic [AW-1:0] wgt_waddr, wgt_raddr;
  logic [DW-1:0] wgt_wdata, wgt_rdata;

  logic          div_start, div_done;
  logic [PW-1:0] div_den;
  logic [ccwm_pkg::NUM_W-1:0] div_quo;

  ccwm_pkg::ccwm_entry_t entry, upd_entry;
  logic          accept;
  logic          is_cut, is_full, is_freq;
  logic          reject;
  logic          rd_ok;
  logic          sweep_last;
  logic          walk_end;
  logic          take;
  logic [CW-1:0] chk_row;
  logic [DW:0]   sum;

  assign accept  = in_valid && in_ready;
  assign is_cut  = mode == ccwm_pkg::MODE_CUT;
  assign is_full = mode == ccwm_pkg::MODE_FULL;
  assign is_freq = !is_cut && !is_full;
  assign entry   = ccwm_pkg::ccwm_entry_t'(tbl_rdata);

  always_comb begin
    reject = (int'(in_call_index) >= ccwm_pkg::NUM_CALLS) ||
             (pos_r == PW'(ccwm_pkg::MAX_TRACE));
    rd_ok  = (int'(in_row) < ccwm_pkg::NUM_CALLS) &&
             (is_freq || (int'(in_col) < ccwm_pkg::NUM_CALLS));
    sweep_last = sweep_cnt_r == AW'(ccwm_pkg::NUM_CALLS * ccwm_pkg::NUM_CALLS - 1);
    walk_end   = is_cut ? (walk_cnt_r == WW'(ccwm_pkg::NUM_CALLS))
                        : (walk_cnt_r == WW'(pos_r));
    if (is_cut) begin
      take    = entry.seen && (CW'(walk_cnt_r) != idx_r);
      chk_row = CW'(walk_cnt_r);
      div_den = pos_r - PW'(entry.last);
    end else begin
      take    = 1'b1;
      chk_row = hist_rdata;
      div_den = pos_r - PW'(walk_cnt_r);
    end
    sum = {1'b0, wgt_rdata} + (DW + 1)'(div_quo);
    upd_entry.seen  = 1'b1;
    upd_entry.last  = ccwm_pkg::LAST_W'(pos_r);
    upd_entry.count = (entry.count == ccwm_pkg::COUNT_MAX) ? entry.count
                                                           : entry.count + 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccwm_pkg::ST_SWEEP:
        if (sweep_last) begin
          state_nxt = sweep_resp_r ? ccwm_pkg::ST_RESP : ccwm_pkg::ST_IDLE;
        end
      ccwm_pkg::ST_IDLE:
        if (in_valid) begin
          case (in_func)
            ccwm_pkg::FUNC_PUSH: begin
              if (reject) begin
                state_nxt = ccwm_pkg::ST_RESP;
              end else if (is_freq) begin
                state_nxt = ccwm_pkg::ST_UPD_RD;
              end else begin
                state_nxt = ccwm_pkg::ST_WALK_RD;
              end
            end
            ccwm_pkg::FUNC_READ:  state_nxt = ccwm_pkg::ST_RD_WAIT;
            ccwm_pkg::FUNC_CLEAR: state_nxt = ccwm_pkg::ST_SWEEP;
            default:              state_nxt = ccwm_pkg::ST_RESP;
          endcase
        end
      ccwm_pkg::ST_WALK_RD:
        state_nxt = walk_end ? ccwm_pkg::ST_UPD_RD : ccwm_pkg::ST_WALK_CHK;
      ccwm_pkg::ST_WALK_CHK:
        state_nxt = take ? ccwm_pkg::ST_DIV : ccwm_pkg::ST_WALK_RD;
      ccwm_pkg::ST_DIV:
        if (div_done) begin
          state_nxt = ccwm_pkg::ST_ACC;
        end
      ccwm_pkg::ST_ACC:     state_nxt = ccwm_pkg::ST_WALK_RD;
      ccwm_pkg::ST_UPD_RD:  state_nxt = ccwm_pkg::ST_UPD_WR;
      ccwm_pkg::ST_UPD_WR:  state_nxt = ccwm_pkg::ST_RESP;
      ccwm_pkg::ST_RD_WAIT: state_nxt = ccwm_pkg::ST_RESP;
      ccwm_pkg::ST_RESP:
        if (res_taken) begin
          state_nxt = ccwm_pkg::ST_IDLE;
        end
      default: state_nxt = ccwm_pkg::ST_SWEEP;
    endcase
  end

  // memory and divider controls
  always_comb begin
    in_ready   = state_r == ccwm_pkg::ST_IDLE;
    res_valid  = state_r == ccwm_pkg::ST_RESP;
    tbl_we     = 1'b0;
    tbl_waddr  = idx_r;
    tbl_wdata  = EW'(upd_entry);
    tbl_re     = 1'b0;
    tbl_raddr  = idx_r;
    hist_we    = 1'b0;
    hist_waddr = ccwm_pkg::HIST_AW'(pos_r);
    hist_wdata = idx_r;
    hist_re    = 1'b0;
    hist_raddr = ccwm_pkg::HIST_AW'(walk_cnt_r);
    wgt_we     = 1'b0;
    wgt_waddr  = {wrow_r, idx_r};
    wgt_wdata  = sum[DW] ? ccwm_pkg::WEIGHT_MAX : sum[DW-1:0];
    wgt_re     = 1'b0;
    wgt_raddr  = {chk_row, idx_r};
    div_start  = 1'b0;
    unique case (state_r)
      ccwm_pkg::ST_SWEEP: begin
        tbl_we    = int'(sweep_cnt_r) < ccwm_pkg::NUM_CALLS;
        tbl_waddr = CW'(sweep_cnt_r);
        tbl_wdata = '0;
        wgt_we    = 1'b1;
        wgt_waddr = sweep_cnt_r;
        wgt_wdata = '0;
      end
      ccwm_pkg::ST_IDLE:
        if (accept && in_func == ccwm_pkg::FUNC_READ) begin
          tbl_re    = is_freq;
          tbl_raddr = CW'(in_row);
          wgt_re    = !is_freq;
          wgt_raddr = {CW'(in_row), CW'(in_col)};
        end
      ccwm_pkg::ST_WALK_RD: begin
        tbl_re    = !walk_end && is_cut;
        tbl_raddr = CW'(walk_cnt_r);
        hist_re   = !walk_end && !is_cut;
      end
      ccwm_pkg::ST_WALK_CHK: begin
        div_start = take;
        wgt_re    = take;
      end
      ccwm_pkg::ST_ACC:    wgt_we = 1'b1;
      ccwm_pkg::ST_UPD_RD: tbl_re = 1'b1;
      ccwm_pkg::ST_UPD_WR: begin
        tbl_we  = 1'b1;
        hist_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ccwm_pkg::ST_SWEEP;
      sweep_cnt_r  <= '0;
      sweep_resp_r <= 1'b0;
      pos_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ccwm_pkg::ST_SWEEP) begin
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end
      if (accept) begin
        walk_cnt_r   <= '0;
        idx_r        <= CW'(in_call_index);
        rd_ok_r      <= rd_ok;
        res_weight_r <= '0;
        res_count_r  <= '0;
        res_status_r <= (in_func == ccwm_pkg::FUNC_PUSH) && reject;
        sweep_resp_r <= 1'b1;
        sweep_cnt_r  <= '0;
        if (in_func == ccwm_pkg::FUNC_CLEAR) begin
          pos_r <= '0;
        end
      end
      if (state_r == ccwm_pkg::ST_WALK_CHK) begin
        wrow_r <= chk_row;
        if (!take) begin
          walk_cnt_r <= walk_cnt_r + 1'b1;
        end
      end
      if (state_r == ccwm_pkg::ST_ACC) begin
        walk_cnt_r <= walk_cnt_r + 1'b1;
      end
      if (state_r == ccwm_pkg::ST_UPD_WR) begin
        pos_r <= pos_r + 1'b1;
      end
      if (state_r == ccwm_pkg::ST_RD_WAIT && rd_ok_r) begin
        if (is_freq) begin
          res_count_r <= entry.count;
        end else begin
          res_weight_r <= wgt_rdata;
        end
      end
    end
  end

  always_comb begin
    res.weight     = res_weight_r;
    res.count      = res_count_r;
    res.calls_seen = (int'(pos_r) > int'(ccwm_pkg::COUNT_MAX)) ? ccwm_pkg::COUNT_MAX
                                                              : ccwm_pkg::COUNT_W'(pos_r);
    res.status     = res_status_r;
  end

  ccwm_ram #(.DW(EW), .AW(CW)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  ccwm_ram #(.DW(CW), .AW(ccwm_pkg::HIST_AW)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
  );

  ccwm_ram #(.DW(DW), .AW(AW)) u_wgt (
    .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
    .re(wgt_re), .raddr(wgt_raddr), .rdata(wgt_rdata)
  );

  ccwm_recip u_recip (
    .clk(clk), .rst_n(rst_n), .start(div_start), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  `CCWM_ASSERT(a_pos_bound, pos_r <= PW'(ccwm_pkg::MAX_TRACE))
  `CCWM_ASSERT(a_wgt_we_src, wgt_we |-> (state_r == ccwm_pkg::ST_ACC || state_r == ccwm_pkg::ST_SWEEP))
  `CCWM_ASSERT_NEXT(a_acc_step, state_r == ccwm_pkg::ST_ACC, walk_cnt_r == $past(walk_cnt_r) + 1'b1)
  `CCWM_ASSERT_NEXT(a_push_pos, state_r == ccwm_pkg::ST_UPD_WR, pos_r == $past(pos_r) + 1'b1)

endmodule

// File: src/call_cooccurrence_weight_matrix.sv
// ----------------------------------------------------------------------------
// call_cooccurrence_weight_matrix
// Call trace co-occurrence weights (Q16.32) or call frequency histogram.
// ----------------------------------------------------------------------------
// Items are handled one at a time; every item returns exactly one result.
// A push in cut mode walks all 512 call-table entries: an entry that does not
// count is read and checked, and one that does also goes through the
// bit-serial reciprocal divider (33 quotient bits, one per cycle) and an
// accumulate into its weight cell. In non-cut mode the walk covers every
// earlier trace position at the same cost per position, so the cost of a push
// grows with its position. A frequency-mode push skips the walk. After reset
// and on each clear item the block sweeps the weight memory (262144 entries,
// one entry a cycle) and the call table with it; no item is accepted during
// the sweep, and a clear item's result comes out when its sweep ends. The
// mode register may be written at any time the block is idle. A finished
// result sits in the output register while the next item is already taken.
module call_cooccurrence_weight_matrix (
  input  logic                        clk,
  input  logic                        rst_n,
  ccwm_in_if.sink                     in_ch,
  ccwm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [ccwm_pkg::MODE_W-1:0] cfg_wdata
);

  logic [ccwm_pkg::MODE_W-1:0] mode_r;

  // output register
  logic                   out_vld_r;
  ccwm_pkg::ccwm_result_t out_res_r;

  logic                   res_valid;
  logic                   res_taken;
  ccwm_pkg::ccwm_result_t res;

  // mode register, reset to cut mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ccwm_pkg::MODE_CUT;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  ccwm_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_func      (in_ch.func),
    .in_call_index(in_ch.call_index),
    .in_row       (in_ch.row),
    .in_col       (in_ch.col),
    .res_valid    (res_valid),
    .res_taken    (res_taken),
    .res          (res)
  );

  // core result moves on when the output register is free or being drained
  assign res_taken = res_valid && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      if (res_taken) begin
        out_vld_r <= 1'b1;
        out_res_r <= res;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.weight     = out_res_r.weight;
  assign out_ch.count      = out_res_r.count;
  assign out_ch.calls_seen = out_res_r.calls_seen;
  assign out_ch.status     = out_res_r.status;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the call co-occurrence weight matrix: a directed
// table after reset, then random traces in cut, non-cut, frequency and
// mode-3 settings, all checked against a behavioral matrix and histogram
// kept in the bench.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ccwm_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;   // unused func code
  localparam logic [ccwm_pkg::MODE_W-1:0] MODE_FREQ = 2'd2;
  localparam logic [ccwm_pkg::MODE_W-1:0] MODE_ALT  = 2'd3;   // behaves as frequency mode
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [ccwm_pkg::FUNC_W-1:0]  func;
    logic [ccwm_pkg::FIELD_W-1:0] call_index;
    logic [ccwm_pkg::FIELD_W-1:0] row;
    logic [ccwm_pkg::FIELD_W-1:0] col;
    bit                           typed;   // expected result given in the table
    ccwm_pkg::ccwm_result_t       res;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [ccwm_pkg::MODE_W-1:0]  cfg_wdata = '0;

  ccwm_in_if  in_ch();
  ccwm_out_if out_ch();

  call_cooccurrence_weight_matrix u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the matrix, histogram and trace
  // --------------------------------------------------------------------------
  logic [ccwm_pkg::WEIGHT_W-1:0] wt_cells [int];          // sparse; absent means zero
  logic [ccwm_pkg::COUNT_W-1:0]  bin_count [ccwm_pkg::NUM_CALLS];
  int unsigned                   last_pos  [ccwm_pkg::NUM_CALLS];
  bit                            seen      [ccwm_pkg::NUM_CALLS];
  int unsigned                   trace     [ccwm_pkg::MAX_TRACE];
  int unsigned                   trace_len;
  logic [ccwm_pkg::MODE_W-1:0]   cur_mode;

  ccwm_pkg::ccwm_result_t expected_results[$];
  int mismatches = 0;

  function automatic logic [63:0] recip_q32(int unsigned d);
    logic [63:0] one;
    one = 64'd1 << ccwm_pkg::FRAC_BITS;
    if (d == 0) d = 1;
    return (one + 64'(d >> 1)) / 64'(d);
  endfunction

  function automatic void add_weight(int unsigned r, int unsigned c, int unsigned d);
    int   k;
    logic [63:0] s;
    k = r * ccwm_pkg::NUM_CALLS + c;
    s = (wt_cells.exists(k) ? 64'(wt_cells[k]) : 64'd0) + recip_q32(d);
    wt_cells[k] = (s > 64'(ccwm_pkg::WEIGHT_MAX)) ? ccwm_pkg::WEIGHT_MAX
                                                  : s[ccwm_pkg::WEIGHT_W-1:0];
  endfunction

  function automatic void clear_model();
    wt_cells.delete();
    foreach (bin_count[i]) begin
      bin_count[i] = '0;
      last_pos[i]  = 0;
      seen[i]      = 1'b0;
    end
    trace_len = 0;
  endfunction

  // Applies one transfer to the copy and returns what the block must answer.
  function automatic ccwm_pkg::ccwm_result_t model_result(stim_t s);
    ccwm_pkg::ccwm_result_t r;
    int unsigned  idx, k;
    r = '0;
    idx = s.call_index;
    case (s.func)
      ccwm_pkg::FUNC_PUSH: begin
        if (trace_len >= ccwm_pkg::MAX_TRACE) begin
          r.status = 1'b1;        // trace full, push dropped
        end else begin
          if (cur_mode == ccwm_pkg::MODE_CUT) begin
            // only the latest occurrence of each other index counts
            for (int c = 0; c < ccwm_pkg::NUM_CALLS; c++)
              if (seen[c] && c != idx) add_weight(c, idx, trace_len - last_pos[c]);
          end else if (cur_mode == ccwm_pkg::MODE_FULL) begin
            for (int q = 0; q < trace_len; q++)
              add_weight(trace[q], idx, trace_len - q);
          end
          if (bin_count[idx] != ccwm_pkg::COUNT_MAX) bin_count[idx]++;
          trace[trace_len] = idx;
          last_pos[idx]    = trace_len;
          seen[idx]        = 1'b1;
          trace_len++;
        end
      end
      ccwm_pkg::FUNC_READ: begin
        if (cur_mode >= MODE_FREQ) r.count = bin_count[s.row];
        else begin
          k = s.row * ccwm_pkg::NUM_CALLS + s.col;
          r.weight = wt_cells.exists(k) ? wt_cells[k] : '0;
        end
      end
      ccwm_pkg::FUNC_CLEAR: clear_model();
      default: ;
    endcase
    r.calls_seen = ccwm_pkg::COUNT_W'(trace_len);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern plus a long hold on request
  // --------------------------------------------------------------------------
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;
  int epoch_cnt = 0;
  bit stall_epoch = 1'b0;

  always @(posedge clk) begin
    epoch_cnt++;
    if (epoch_cnt % 80 == 0) stall_epoch = ($urandom_range(0, 1) != 0);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_epoch ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // Checker: each result transfer against the oldest expectation.
  always @(posedge clk) begin
    ccwm_pkg::ccwm_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: w=%h c=%0d cs=%0d st=%b", $realtime,
                   out_ch.weight, out_ch.count, out_ch.calls_seen, out_ch.status);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.weight !== want.weight || out_ch.count !== want.count ||
            out_ch.calls_seen !== want.calls_seen || out_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp w=%h c=%0d cs=%0d st=%b, got w=%h c=%0d cs=%0d st=%b",
                     $realtime, want.weight, want.count, want.calls_seen, want.status,
                     out_ch.weight, out_ch.count, out_ch.calls_seen, out_ch.status);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item side
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int unsigned call_pool[12] = '{0, 511, 1, 2, 5, 17, 64, 128, 255, 256, 300, 510};

  // One transfer; idles between bursts, keeps valid high inside a burst.
  task automatic send(stim_t s);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= s.func;
    in_ch.call_index <= s.call_index;
    in_ch.row        <= s.row;
    in_ch.col        <= s.col;
    do @(posedge clk); while (!in_ch.ready);
    // transfer happened at this edge
    begin
      ccwm_pkg::ccwm_result_t r;
      r = model_result(s);
      expected_results.insert(expected_results.size(), s.typed ? s.res : r);
    end
    burst_left--;
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic set_mode(logic [ccwm_pkg::MODE_W-1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
  endtask

  function automatic stim_t rand_item(bit hot);
    stim_t s;
    int p;
    s = '{default: '0};
    s.call_index = ccwm_pkg::FIELD_W'($urandom_range(0, 511));
    s.row = ccwm_pkg::FIELD_W'($urandom_range(0, 511));
    s.col = ccwm_pkg::FIELD_W'($urandom_range(0, 511));
    p = $urandom_range(0, 99);
    if (p < 55) s.func = ccwm_pkg::FUNC_PUSH;
    else if (p < 95) s.func = ccwm_pkg::FUNC_READ;
    else s.func = FUNC_NONE;
    // most traffic hits a small set of calls so the cells fill up
    if (hot && $urandom_range(0, 4) != 0) begin
      s.call_index = ccwm_pkg::FIELD_W'(call_pool[$urandom_range(0, 11)]);
      s.row = ccwm_pkg::FIELD_W'(call_pool[$urandom_range(0, 11)]);
      s.col = ccwm_pkg::FIELD_W'(call_pool[$urandom_range(0, 11)]);
    end
    return s;
  endfunction

  function automatic stim_t mk(logic [ccwm_pkg::FUNC_W-1:0] f, int i, int r, int c);
    stim_t s;
    s = '{default: '0};
    s.func = f;
    s.call_index = ccwm_pkg::FIELD_W'(i);
    s.row = ccwm_pkg::FIELD_W'(r);
    s.col = ccwm_pkg::FIELD_W'(c);
    return s;
  endfunction

  function automatic stim_t mk_typed(logic [ccwm_pkg::FUNC_W-1:0] f, int i, int r, int c,
                                     logic [ccwm_pkg::WEIGHT_W-1:0] w, int cs);
    stim_t s;
    s = mk(f, i, r, c);
    s.typed = 1'b1;
    s.res = '0;
    s.res.weight = w;
    s.res.calls_seen = ccwm_pkg::COUNT_W'(cs);
    return s;
  endfunction

  stim_t directed[$];

  initial begin
    stim_t s;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.call_index = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    clear_model();
    cur_mode = ccwm_pkg::MODE_CUT;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, cut mode. After reset everything reads zero; a call
    // repeated right after itself adds nothing to its own cell; adjacent
    // calls give exactly 1.0.
    directed = '{
      mk_typed(ccwm_pkg::FUNC_READ, 0, 0, 0, 0, 0),
      mk_typed(ccwm_pkg::FUNC_READ, 0, 511, 511, 0, 0),
      mk_typed(FUNC_NONE, 511, 511, 511, 0, 0),
      mk_typed(ccwm_pkg::FUNC_PUSH, 5, 0, 0, 0, 1),
      mk_typed(ccwm_pkg::FUNC_PUSH, 5, 0, 0, 0, 2),
      mk(ccwm_pkg::FUNC_PUSH, 511, 0, 0),
      mk(ccwm_pkg::FUNC_PUSH, 0, 0, 0),
      mk_typed(ccwm_pkg::FUNC_READ, 0, 5, 5, 0, 4),
      mk_typed(ccwm_pkg::FUNC_READ, 0, 5, 511, 48'd1 << ccwm_pkg::FRAC_BITS, 4),
      mk(ccwm_pkg::FUNC_READ, 0, 511, 0),
      mk(ccwm_pkg::FUNC_READ, 0, 5, 0),
      mk(ccwm_pkg::FUNC_PUSH, 5, 0, 0),
      mk(ccwm_pkg::FUNC_PUSH, 511, 0, 0),
      mk(ccwm_pkg::FUNC_READ, 0, 0, 5),
      mk(ccwm_pkg::FUNC_READ, 0, 511, 5),
      mk(ccwm_pkg::FUNC_READ, 511, 0, 511),
      mk_typed(ccwm_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0),
      mk_typed(ccwm_pkg::FUNC_READ, 0, 5, 511, 0, 0)
    };
    set_mode(ccwm_pkg::MODE_CUT);
    foreach (directed[i]) send(directed[i]);

    // Non-cut mode on a short trace: walk cost grows with trace length.
    set_mode(ccwm_pkg::MODE_FULL);
    for (int n = 0; n < 70; n++) begin
      s = rand_item(1'b1);
      if (trace_len >= 40 && s.func == ccwm_pkg::FUNC_PUSH) s.func = ccwm_pkg::FUNC_READ;
      send(s);
    end

    // Cut mode continuing the same trace.
    set_mode(ccwm_pkg::MODE_CUT);
    for (int n = 0; n < 220; n++) send(rand_item(1'b1));

    // Frequency mode, with a long receiver hold while items keep coming.
    set_mode(MODE_FREQ);
    for (int n = 0; n < 150; n++) begin
      if (n == 20 || n == 100) hold_req++;
      send(rand_item($urandom_range(0, 1) != 0));
    end

    // Mode 3 acts as frequency mode: pushes count bins, reads return them.
    set_mode(MODE_ALT);
    for (int n = 0; n < 60; n++) send(rand_item(1'b1));

    // Back to cut mode on the grown trace: cells built earlier remain.
    set_mode(ccwm_pkg::MODE_CUT);
    for (int n = 0; n < 30; n++) send(rand_item(1'b1));

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: two weight sweeps plus all walks fit well inside this.
  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/ccwm_pkg.sv
src/ccwm_in_if.sv
src/ccwm_out_if.sv
src/ccwm_ram.sv
src/ccwm_recip.sv
src/ccwm_core.sv
src/call_cooccurrence_weight_matrix.sv
tb/tb.sv
